[design/sukt_pkg.sv]
// Package for the sorted unique key table.
// Holds the item types, the controller state type and the command group.
// It depends on nothing else.
`default_nettype none

package sukt_pkg;

    // Number of entries when the top level is not told otherwise.
    localparam int CAPACITY_DEF = 16;

    // Width of the entry count carried in a result item.
    localparam int ENTRY_W = 5;

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [31:0] key_value;
        logic signed [31:0] point_value;
    } in_item_t;

    typedef struct packed {
        logic               ok;
        logic [ENTRY_W-1:0] entry_count;
    } out_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic compare;
        logic update;
    } ctl_cmd_t;

endpackage

`default_nettype wire

[design/sukt_ctrl.sv]
// Controller for the sorted unique key table.
// Sequences capture, compare and update of one item and owns the result valid.
// Depends on sukt_pkg.
`default_nettype none

module sukt_ctrl
    import sukt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_stall,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output ctl_cmd_t      ctl
);

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       out_blocked;

    // The result register is busy while a result waits on a stalled receiver.
    assign out_blocked = rsp_valid_reg && rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (!out_blocked)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_stall   = 1'b1;
        ctl.capture = 1'b0;
        ctl.compare = 1'b0;
        ctl.update  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_stall   = 1'b0;
                ctl.capture = cmd_valid;
            end
            S_CMP:
            begin
                ctl.compare = 1'b1;
            end
            S_UPD:
            begin
                ctl.update = !out_blocked;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.update)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            rsp_valid_next = rsp_valid_reg;
        end
        else
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

[design/sukt_dpath.sv]
// Datapath for the sorted unique key table.
// A row of entry cells that compare against the item key and shift in parallel.
// Depends on sukt_pkg.
`default_nettype none

module sukt_dpath
    import sukt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_item_t cmd,
    input  wire ctl_cmd_t ctl,
    output out_item_t     rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Entry cells; only entries below the fill count hold meaning.
    logic signed [31:0] key_cell_reg   [CAPACITY];
    logic signed [31:0] point_cell_reg [CAPACITY];
    logic signed [31:0] key_cell_next  [CAPACITY];
    logic signed [31:0] point_cell_next[CAPACITY];

    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;

    // Captured item.
    logic               op_reg;
    logic signed [31:0] key_in_reg;
    logic signed [31:0] point_in_reg;

    // Per cell compare flags: valid entry below the key, valid entry equal to it.
    logic [CAPACITY-1:0] lt_reg;
    logic [CAPACITY-1:0] eq_reg;
    logic [CAPACITY-1:0] lt_now;
    logic [CAPACITY-1:0] eq_now;

    logic               found;
    logic               full;
    logic               ok;
    out_item_t          rsp_reg;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            lt_now[i] = (CNT_W'(i) < fill_reg) && (key_cell_reg[i] < key_in_reg);
            eq_now[i] = (CNT_W'(i) < fill_reg) && (key_cell_reg[i] == key_in_reg);
        end
    end

    assign found = |eq_reg;
    assign full  = (fill_reg == CNT_W'(CAPACITY));
    assign ok    = (op_reg == OP_INSERT) ? (!full && !found) : found;

    always_comb
    begin
        fill_next = fill_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            key_cell_next[i]   = key_cell_reg[i];
            point_cell_next[i] = point_cell_reg[i];
        end
        if (ctl.update && ok)
        begin
            if (op_reg == OP_INSERT)
            begin
                fill_next = fill_reg + CNT_W'(1);
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (!lt_reg[i])
                    begin
                        if (i == 0)
                        begin
                            key_cell_next[i]   = key_in_reg;
                            point_cell_next[i] = point_in_reg;
                        end
                        else if (lt_reg[(i == 0) ? 0 : i - 1])
                        begin
                            key_cell_next[i]   = key_in_reg;
                            point_cell_next[i] = point_in_reg;
                        end
                        else
                        begin
                            key_cell_next[i]   = key_cell_reg[(i == 0) ? 0 : i - 1];
                            point_cell_next[i] = point_cell_reg[(i == 0) ? 0 : i - 1];
                        end
                    end
                end
            end
            else
            begin
                fill_next = fill_reg - CNT_W'(1);
                for (int i = 0; i < CAPACITY - 1; i++)
                begin
                    if (!lt_reg[i])
                    begin
                        key_cell_next[i]   = key_cell_reg[i + 1];
                        point_cell_next[i] = point_cell_reg[i + 1];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            key_cell_reg[i]   <= key_cell_next[i];
            point_cell_reg[i] <= point_cell_next[i];
        end
        if (ctl.capture)
        begin
            op_reg       <= cmd.op;
            key_in_reg   <= cmd.key_value;
            point_in_reg <= cmd.point_value;
        end
        if (ctl.compare)
        begin
            lt_reg <= lt_now;
            eq_reg <= eq_now;
        end
        if (ctl.update)
        begin
            rsp_reg.ok          <= ok;
            rsp_reg.entry_count <= ENTRY_W'(fill_next);
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

[design/sorted_unique_key_table.sv]
// Top level of the sorted unique key table.
// Joins the controller and the datapath; depends on sukt_pkg, sukt_ctrl and sukt_dpath.
//
// This block holds up to CAPACITY points in ascending order of their signed
// Q16.16 key, never two with the same key. An insert item places its point
// in key order and is refused (ok low) when the key is already held or the
// table is full; a delete item removes the point with its key, wherever it
// sits, and is refused when the key is absent. Every item yields exactly one
// result item with ok and the number of points held afterward. Each entry is
// a cell with its own comparator, so all cells work at once: the item is
// taken in the idle state, all cells compare in the next cycle, and all
// cells shift in the update state that follows, loading the result register.
// A new item is taken only once the last one has passed its update step; a
// stalled result delays the update step until the result register is free.
// The table is empty after reset with no clearing pass. The entry count in a
// result is the fill level truncated to five bits.
`default_nettype none

module sorted_unique_key_table
    import sukt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_stall,
    input  wire in_item_t cmd,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output out_item_t     rsp
);

    ctl_cmd_t ctl;

    sukt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctl       (ctl)
    );

    sukt_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .ctl   (ctl),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

[tb/sorted_unique_key_table_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the sorted unique key table: a scoreboard class that
// mirrors the table contents, plus the top module that drives and watches the block.
// Depends on sukt_pkg and the sorted_unique_key_table RTL only.

import sukt_pkg::*;

// Keeps its own sorted copy of the table and the results that are still owed.
class key_table_scoreboard;
    localparam int DEPTH = CAPACITY_DEF;

    logic signed [31:0] held_keys [DEPTH];
    logic signed [31:0] held_points [DEPTH];
    int unsigned        held_count = 0;
    out_item_t          awaited_results [$];

    int unsigned mismatches = 0;
    int unsigned results_checked = 0;
    int unsigned inserts_taken = 0;
    int unsigned deletes_taken = 0;
    int unsigned refusals = 0;
    int unsigned full_refusals = 0;

    // Applies one accepted command item to the mirror and queues its result.
    function void note_command(in_item_t item);
        logic signed [31:0] key;
        int unsigned        slot;
        int unsigned        j;
        bit                 found;
        out_item_t          want;

        key = item.key_value;
        slot = 0;
        while (slot < held_count && held_keys[slot] < key)
            slot++;
        found = (slot < held_count) && (held_keys[slot] == key);
        want.ok = 1'b0;

        if (item.op == OP_INSERT)
        begin
            if (held_count >= DEPTH)
                full_refusals++;
            else if (!found)
            begin
                for (j = held_count; j > slot; j--)
                begin
                    held_keys[j] = held_keys[j - 1];
                    held_points[j] = held_points[j - 1];
                end
                held_keys[slot] = key;
                held_points[slot] = item.point_value;
                held_count++;
                want.ok = 1'b1;
                inserts_taken++;
            end
        end
        else if (found)
        begin
            for (j = slot; j + 1 < held_count; j++)
            begin
                held_keys[j] = held_keys[j + 1];
                held_points[j] = held_points[j + 1];
            end
            held_count--;
            want.ok = 1'b1;
            deletes_taken++;
        end

        if (!want.ok)
            refusals++;
        want.entry_count = held_count[ENTRY_W-1:0];
        awaited_results.push_back(want);
    endfunction

    // Compares one accepted result item with the oldest one owed.
    function void check_response(out_item_t got);
        out_item_t want;

        if (awaited_results.size() == 0)
        begin
            $error("result item with none pending: ok %0d, entry_count %0d",
                   got.ok, got.entry_count);
            mismatches++;
        end
        else
        begin
            want = awaited_results.pop_front();
            results_checked++;
            if (got.ok !== want.ok)
            begin
                $error("ok: expected %0d, actual %0d", want.ok, got.ok);
                mismatches++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $error("entry_count: expected %0d, actual %0d",
                       want.entry_count, got.entry_count);
                mismatches++;
            end
        end
    endfunction
endclass

module sorted_unique_key_table_tb;

    localparam int CLK_HALF      = 4;       // 8 ns period
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int IDLE_PCT      = 14;      // chance per cycle that a side holds off
    localparam int QUIET_FIRST   = 700;     // random items in this window run
    localparam int QUIET_LAST    = 1100;    // with no idling on either side
    localparam int POOL_SIZE     = 24;      // a few more keys than the table holds
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 200000;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    in_item_t  cmd;
    logic      rsp_valid;
    logic      rsp_stall;
    out_item_t rsp;

    key_table_scoreboard board;

    // Keys for the random part come mostly from this small pool, so that
    // duplicates, hits on delete and a full table all happen often.
    logic signed [31:0] key_pool [POOL_SIZE];

    // Set by the stimulus during the long stretch without idling; both the
    // command side and the result side look at it.
    bit steady_flow;

    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;

    sorted_unique_key_table #(
        .CAPACITY (CAPACITY_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #CLK_HALF clk = ~clk;
    end

    // Hard stop in case the block hangs or drops a result.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("run did not finish within %0d cycles", CYCLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic in_item_t make_command(logic op, logic [31:0] key, logic [31:0] point);
        in_item_t item;

        item.op = op;
        item.key_value = key;
        item.point_value = point;
        return item;
    endfunction

    // Builds one random command item. The share of inserts rotates every hundred
    // items through high, balanced and low, so the table swings between full and
    // empty again and again. Deletes often aim at a key that is held right now.
    function automatic in_item_t pick_command(int unsigned n);
        in_item_t    item;
        int unsigned insert_pct;

        case ((n / 100) % 3)
            0:       insert_pct = 85;
            1:       insert_pct = 50;
            default: insert_pct = 15;
        endcase
        item.op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
        item.point_value = $urandom;
        if ($urandom_range(0, 9) == 0)
            item.key_value = $urandom;
        else if (item.op == OP_DELETE && board.held_count > 0 && $urandom_range(0, 1) == 1)
            item.key_value = board.held_keys[$urandom_range(0, board.held_count - 1)];
        else
            item.key_value = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return item;
    endfunction

    // Presents one item, holding it until the block takes it. Idle cycles go in
    // ahead of the item at random; valid is only lowered for those, so back to
    // back items keep valid high with a single assignment per edge. The item is
    // handed to the scoreboard at the edge where it is accepted; the values read
    // right after the edge are the ones the block saw at that edge.
    task automatic send_command(input in_item_t item);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= item;
        do
            @(posedge clk);
        while (cmd_stall);
        board.note_command(item);
        items_sent++;
    endtask

    // Result side: check every accepted result item, then decide the stall for
    // the next edge. Stalls come at random outside the steady stretch.
    initial
    begin
        rsp_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                board.check_response(rsp);
            rsp_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial
    begin
        int unsigned i;
        int unsigned n;

        board = new();
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        steady_flow = 1'b0;

        // The pool holds the signed extremes, the keys on either side of zero,
        // and random keys of both signs.
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h8000_0001;
        key_pool[2] = 32'h7FFF_FFFF;
        key_pool[3] = 32'h7FFF_FFFE;
        key_pool[4] = 32'h0000_0000;
        key_pool[5] = 32'hFFFF_FFFF;
        key_pool[6] = 32'h0000_0001;
        for (i = 7; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A delete on the empty table comes first, then the
        // signed extremes as keys with extreme values, a duplicate of the head,
        // a duplicate in the middle, a delete of a missing key, deletes of the
        // head and the tail, and a new head.
        send_command(make_command(OP_DELETE, 32'h0000_0000, 32'h1234_5678));
        send_command(make_command(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF));
        send_command(make_command(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000));
        send_command(make_command(OP_INSERT, 32'h8000_0000, 32'h0000_0000));
        send_command(make_command(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF));
        send_command(make_command(OP_INSERT, 32'hFFFF_FFFF, 32'h0001_0000));
        send_command(make_command(OP_INSERT, 32'h0000_0001, 32'h5555_5555));
        send_command(make_command(OP_INSERT, 32'h0000_0000, 32'hAAAA_AAAA));
        send_command(make_command(OP_DELETE, 32'h0002_0000, 32'h0000_0000));
        send_command(make_command(OP_DELETE, 32'h8000_0000, 32'h0000_0000));
        send_command(make_command(OP_DELETE, 32'h7FFF_FFFF, 32'h0000_0000));
        send_command(make_command(OP_INSERT, 32'h8000_0000, 32'h0000_0000));

        // Four points are held now. Fill the table with keys of both signs,
        // then offer one more insert, which must be refused as the table is full.
        for (i = 0; i < 12; i++)
        begin
            if (i % 2 == 0)
                send_command(make_command(OP_INSERT, (100 + i) << 16, $urandom));
            else
                send_command(make_command(OP_INSERT, -((100 + i) << 16), $urandom));
        end
        send_command(make_command(OP_INSERT, 32'h0003_0000, $urandom));

        // Random part.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady_flow = (n >= QUIET_FIRST) && (n < QUIET_LAST);
            send_command(pick_command(n));
        end
        steady_flow = 1'b0;
        cmd_valid <= 1'b0;

        // Drain: wait for every owed result, then give any stray result time
        // to show up.
        while (board.awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("summary: %0d command items sent, %0d results checked, %0d mismatches",
                 items_sent, board.results_checked, board.mismatches);
        $display("summary: %0d inserts and %0d deletes done, %0d refused (%0d on a full table)",
                 board.inserts_taken, board.deletes_taken, board.refusals,
                 board.full_refusals);
        if (board.mismatches == 0 && board.awaited_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
design/sukt_pkg.sv
design/sukt_ctrl.sv
design/sukt_dpath.sv
design/sorted_unique_key_table.sv
tb/sorted_unique_key_table_tb.sv
